FILE: sv/irld_pkg.sv
`timescale 1ns / 1ps

package irld_pkg;

  localparam int unsigned LineW     = 10;
  localparam int unsigned PatW      = 4;
  localparam int unsigned RowW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned OutDataW  = 80;

  localparam logic [LineW-1:0] MaxLineBytes = 10'd512;
  localparam logic [PatW-1:0]  MaxPatBytes  = 4'd8;

  // stream byte codes
  localparam logic [7:0] BytePatRun  = 8'h00;
  localparam logic [7:0] ByteLiteral = 8'h80;
  localparam logic [7:0] ByteRptMark = 8'hFF;
  localparam logic [7:0] ByteSolidHi = 8'hFF;
  localparam logic [7:0] ByteSolidLo = 8'h00;
  localparam logic [6:0] RunLenMask  = 7'h7F;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_LINE_BYTES    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_BYTES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_ROWS    = 2'd2;

  typedef enum logic [3:0] {
    PH_LINE_START,
    PH_HDR0,
    PH_HDR00,
    PH_HDR_N,
    PH_TAG,
    PH_PAT_COUNT,
    PH_PAT_DATA,
    PH_LIT_COUNT,
    PH_LIT_DATA
  } phase_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

endpackage

FILE: sv/img_run_length_line_decoder.sv
`timescale 1ns / 1ps

// Run-length line decoder. Takes one compressed byte per beat on the slave side and
// gives decoded raster bytes on the master side, packed up to eight per beat, first
// byte in the low bits. The beat that fills a line has line_end set and carries the
// line's repeat count (from an optional 00 00 FF n line header, clipped to the rows
// left in the image). tlast marks the final output beat caused by one input byte.
// Flow: a byte that decodes to nothing (headers, counts, inner pattern bytes,
// bytes after the image is complete) leaves the input ready for the next byte. A
// byte that decodes to N bytes sends them one per cycle, while the output is not
// stalled, through a single byte emitter (a down counter, a pattern pointer and an
// 8-lane packer), and the input is not ready while it runs. N is at most the
// bytes left in the line (<= 512).
// Config (line_bytes, pattern_bytes, image_rows) may be written only while idle.
module img_run_length_line_decoder import irld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] compressed_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [63:0] decoded_bytes, [67:64] byte_count, [68] line_end, [76:69] line_repeat,
  // [79:77] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast    // last
);

  // config registers
  logic [LineW-1:0] line_bytes_q;
  logic [PatW-1:0]  pat_bytes_q;
  logic [RowW-1:0]  image_rows_q;

  // parser state
  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [LineW-1:0] bil_q, bil_d;
  logic [7:0]       rc_q, rc_d;
  logic [63:0]      pstore_q, pstore_d;
  logic [2:0]       pidx_q, pidx_d;
  logic [7:0]       vrep_q, vrep_d;
  logic [RowW-1:0]  rows_q, rows_d;

  // emitter state
  logic [LineW-1:0] rem_q, rem_d;
  logic [2:0]       ptr_q, ptr_d;
  logic [63:0]      acc_q, acc_d;
  logic [2:0]       acc_len_q, acc_len_d;
  logic             pat_mode_q, pat_mode_d;
  logic [7:0]       src_q, src_d;
  logic             le_q, le_d;
  logic [7:0]       rep_q, rep_d;

  // output register
  logic             ovalid_q, ovalid_d;
  logic [63:0]      odata_q, odata_d;
  logic [3:0]       ocnt_q, ocnt_d;
  logic             oend_q, oend_d;
  logic [7:0]       orep_q, orep_d;
  logic             olast_q, olast_d;

  // effective register values
  logic [LineW-1:0] eff_line;
  logic [PatW-1:0]  eff_pat;

  always_comb begin
    eff_line = line_bytes_q;
    if (line_bytes_q == '0) begin
      eff_line = LineW'(1);
    end else if (line_bytes_q > MaxLineBytes) begin
      eff_line = MaxLineBytes;
    end
    eff_pat = pat_bytes_q;
    if (pat_bytes_q == '0) begin
      eff_pat = PatW'(1);
    end else if (pat_bytes_q > MaxPatBytes) begin
      eff_pat = MaxPatBytes;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  logic             in_beat, active;
  logic [7:0]       b;
  logic             do_tag, do_pat, end_cmd, closes;
  logic [2:0]       pat_idx;
  logic [11:0]      want;
  logic [LineW-1:0] avail, tcnt;
  logic [LineW:0]   bil_sum;
  logic [RowW-1:0]  rows_left;
  logic [7:0]       rep_c;

  // emitter signals
  logic [7:0]       ebyte;
  logic [63:0]      acc_ins;
  logic             word_done, out_free, advance;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign active  = in_beat && (rows_q < image_rows_q);
  assign b       = s_axis_tdata;
  assign out_free = !ovalid_q || m_axis_tready;

  always_comb begin
    ebyte = pat_mode_q ? pstore_q[{ptr_q, 3'b000} +: 8] : src_q;
    acc_ins = acc_q;
    for (int k = 0; k < 8; k++) begin
      if (acc_len_q == 3'(k)) acc_ins[8*k +: 8] = ebyte;
    end
  end

  assign word_done = (acc_len_q == 3'd7) || (rem_q == LineW'(1));
  assign advance   = (state_q == ST_EMIT) && (!word_done || out_free);

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    bil_d      = bil_q;
    rc_d       = rc_q;
    pstore_d   = pstore_q;
    pidx_d     = pidx_q;
    vrep_d     = vrep_q;
    rows_d     = rows_q;
    rem_d      = rem_q;
    ptr_d      = ptr_q;
    acc_d      = acc_q;
    acc_len_d  = acc_len_q;
    pat_mode_d = pat_mode_q;
    src_d      = src_q;
    le_d       = le_q;
    rep_d      = rep_q;
    ovalid_d   = ovalid_q && !m_axis_tready;
    odata_d    = odata_q;
    ocnt_d     = ocnt_q;
    oend_d     = oend_q;
    orep_d     = orep_q;
    olast_d    = olast_q;

    do_tag  = 1'b0;
    do_pat  = 1'b0;
    end_cmd = 1'b0;
    pat_idx = pidx_q;
    want    = '0;
    avail   = '0;
    tcnt    = '0;
    bil_sum = '0;
    closes  = 1'b0;
    rows_left = image_rows_q - rows_q;
    rep_c   = vrep_q;
    if ({8'h00, vrep_q} > rows_left) rep_c = rows_left[7:0];
    if (rep_c == 8'h00) rep_c = 8'h01;

    if (active) begin
      src_d      = b;
      pat_mode_d = 1'b0;
      case (phase_q)
        PH_LINE_START: begin
          if (b == BytePatRun) phase_d = PH_HDR0;
          else do_tag = 1'b1;
        end
        PH_HDR0: begin
          if (b == BytePatRun) begin
            phase_d = PH_HDR00;
          end else begin
            rc_d    = b;
            pidx_d  = 3'd0;
            phase_d = PH_PAT_DATA;
          end
        end
        PH_HDR00: begin
          if (b == ByteRptMark) begin
            phase_d = PH_HDR_N;
          end else begin
            // 00 00 x: empty pattern run whose first pattern byte is x
            rc_d    = 8'h00;
            pat_idx = 3'd0;
            do_pat  = 1'b1;
          end
        end
        PH_HDR_N: begin
          vrep_d  = (b == 8'h00) ? 8'h01 : b;
          phase_d = PH_TAG;
        end
        PH_PAT_COUNT: begin
          rc_d    = b;
          pidx_d  = 3'd0;
          phase_d = PH_PAT_DATA;
        end
        PH_PAT_DATA: begin
          do_pat = 1'b1;
        end
        PH_LIT_COUNT: begin
          rc_d = b;
          if (b == 8'h00) end_cmd = 1'b1;
          else phase_d = PH_LIT_DATA;
        end
        PH_LIT_DATA: begin
          want = 12'd1;
          rc_d = rc_q - 8'd1;
          if (rc_q == 8'd1) end_cmd = 1'b1;
        end
        default: begin
          do_tag = 1'b1;
        end
      endcase

      if (do_tag) begin
        if (b == BytePatRun) begin
          phase_d = PH_PAT_COUNT;
        end else if (b == ByteLiteral) begin
          phase_d = PH_LIT_COUNT;
        end else begin
          want    = {5'd0, b[6:0] & RunLenMask};
          src_d   = b[7] ? ByteSolidHi : ByteSolidLo;
          end_cmd = 1'b1;
        end
      end

      if (do_pat) begin
        pstore_d[{pat_idx, 3'b000} +: 8] = b;
        if ({1'b0, pat_idx} + 4'd1 >= eff_pat) begin
          pidx_d     = 3'd0;
          want       = {4'd0, rc_d} * {8'd0, eff_pat};
          pat_mode_d = 1'b1;
          end_cmd    = 1'b1;
        end else begin
          pidx_d  = pat_idx + 3'd1;
          phase_d = PH_PAT_DATA;
        end
      end

      // clip to the room left in the line
      if (bil_q < eff_line) avail = eff_line - bil_q;
      tcnt = (want < {2'b00, avail}) ? want[LineW-1:0] : avail;
      bil_sum = {1'b0, bil_q} + {1'b0, tcnt};
      closes = (bil_sum >= {1'b0, eff_line});

      bil_d = bil_sum[LineW-1:0];
      if (end_cmd) begin
        if (closes) begin
          bil_d   = '0;
          phase_d = PH_LINE_START;
        end else begin
          phase_d = PH_TAG;
        end
      end

      le_d  = (tcnt != '0) && closes;
      rep_d = rep_c;
      if ((tcnt != '0) && closes) begin
        rows_d = rows_q + {8'h00, rep_c};
        vrep_d = 8'h01;
      end

      rem_d     = tcnt;
      ptr_d     = 3'd0;
      acc_d     = '0;
      acc_len_d = 3'd0;
      if (tcnt != '0) state_d = ST_EMIT;
    end

    if (advance) begin
      rem_d = rem_q - LineW'(1);
      if ({1'b0, ptr_q} + 4'd1 >= eff_pat) ptr_d = 3'd0;
      else ptr_d = ptr_q + 3'd1;
      if (word_done) begin
        acc_d     = '0;
        acc_len_d = 3'd0;
        ovalid_d  = 1'b1;
        odata_d   = acc_ins;
        ocnt_d    = {1'b0, acc_len_q} + 4'd1;
        oend_d    = (rem_q == LineW'(1)) && le_q;
        orep_d    = ((rem_q == LineW'(1)) && le_q) ? rep_q : 8'h01;
        olast_d   = (rem_q == LineW'(1));
      end else begin
        acc_d     = acc_ins;
        acc_len_d = acc_len_q + 3'd1;
      end
      if (rem_q == LineW'(1)) state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q <= LineW'(80);
      pat_bytes_q  <= PatW'(2);
      image_rows_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_BYTES:    line_bytes_q <= cfg_data_i[LineW-1:0];
        CFG_PATTERN_BYTES: pat_bytes_q  <= cfg_data_i[PatW-1:0];
        CFG_IMAGE_ROWS:    image_rows_q <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_LINE_START;
      bil_q      <= '0;
      rc_q       <= '0;
      pstore_q   <= '0;
      pidx_q     <= '0;
      vrep_q     <= 8'h01;
      rows_q     <= '0;
      rem_q      <= '0;
      ptr_q      <= '0;
      acc_len_q  <= '0;
      pat_mode_q <= 1'b0;
      le_q       <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      bil_q      <= bil_d;
      rc_q       <= rc_d;
      pstore_q   <= pstore_d;
      pidx_q     <= pidx_d;
      vrep_q     <= vrep_d;
      rows_q     <= rows_d;
      rem_q      <= rem_d;
      ptr_q      <= ptr_d;
      acc_len_q  <= acc_len_d;
      pat_mode_q <= pat_mode_d;
      le_q       <= le_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    src_q   <= src_d;
    rep_q   <= rep_d;
    odata_q <= odata_d;
    ocnt_q  <= ocnt_d;
    oend_q  <= oend_d;
    orep_q  <= orep_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, orep_q, oend_q, ocnt_q, odata_q};
  assign m_axis_tlast  = olast_q;

  // checks
  a_idle_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (rem_q == '0))
    else $error("emitter count left over in idle");

  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oend_q) |-> olast_q)
    else $error("line end beat not last of its byte");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (ocnt_q != 4'd0 && ocnt_q <= 4'd8))
    else $error("byte count out of range");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && pat_mode_q) |-> ({1'b0, ptr_q} < eff_pat))
    else $error("pattern pointer beyond pattern");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !olast_q) |-> (ocnt_q == 4'd8))
    else $error("short word before end of run");

endmodule

FILE: tb/img_run_length_line_decoder_tb.sv
`timescale 1ns / 1ps

module img_run_length_line_decoder_tb;
  import irld_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int HoldCycles = 600;
  localparam int PhaseItems = 40;
  localparam int MaxBeatsPerByte = 64;

  // one expected output beat
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        eol;
    logic [7:0]  reps;
    logic        fin;
  } beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;    // [7:0] compressed_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [63:0] decoded_bytes, [67:64] byte_count, [68] line_end, [76:69] line_repeat
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;          // last

  img_run_length_line_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow: config copy, parser state and the queue of expected beats.
  // ---------------------------------------------------------------------------
  logic [LineW-1:0] cfg_line = 10'd80;
  logic [PatW-1:0]  cfg_pat  = 4'd2;
  logic [RowW-1:0]  cfg_rows = '0;

  phase_e      ph = PH_LINE_START;
  int          line_fill = 0;
  logic [7:0]  cnt = '0;
  logic [63:0] pat_word = '0;
  int          pat_pos = 0;
  logic [7:0]  vrep = 8'd1;
  logic [15:0] rows_seen = '0;

  // packer for the byte being decoded
  logic [63:0] acc;
  int          acc_n;
  int          n_step;

  beat_t       decoded_q[$];
  logic [7:0]  stream_q[$];    // compressed bytes waiting to be offered
  int          n_queued = 0;
  int          n_taken = 0;
  int          n_errors = 0;
  int          n_cycles = 0;

  int send_idle = 0;
  int recv_stall = 0;
  int hold_ask = 0;
  int hold_ack = 0;
  int hold_left = 0;

  // out-of-range register values saturate
  function automatic int line_len_eff();
    int l;
    l = int'(cfg_line);
    if (l == 0) l = 1;
    if (l > int'(MaxLineBytes)) l = int'(MaxLineBytes);
    return l;
  endfunction

  function automatic int pat_len_eff();
    int p;
    p = int'(cfg_pat);
    if (p == 0) p = 1;
    if (p > int'(MaxPatBytes)) p = int'(MaxPatBytes);
    return p;
  endfunction

  function automatic void pack_out(input logic eol, input logic [7:0] reps);
    beat_t b;
    if (acc_n == 0 || n_step >= MaxBeatsPerByte) return;
    b.data   = acc;
    b.nbytes = acc_n[3:0];
    b.eol    = eol;
    b.reps   = reps;
    b.fin    = 1'b0;
    decoded_q.push_back(b);
    n_step++;
    acc   = '0;
    acc_n = 0;
  endfunction

  // one raster byte into the line; closes the line when it fills
  function automatic void put_byte(input logic [7:0] b);
    int l, left, rep;
    l = line_len_eff();
    if (line_fill >= l) return;     // overflow: dropped
    acc[8*acc_n +: 8] = b;
    acc_n++;
    line_fill++;
    if (line_fill >= l) begin
      left = int'(cfg_rows) - int'(rows_seen);
      rep  = int'(vrep);
      if (rep > left) rep = left;   // clip to rows left in image
      if (rep == 0) rep = 1;
      pack_out(1'b1, rep[7:0]);
      rows_seen = rows_seen + rep[15:0];
      vrep = 8'd1;
    end else if (acc_n == 8) begin
      pack_out(1'b0, 8'd1);
    end
  endfunction

  function automatic void close_cmd();
    if (line_fill >= line_len_eff()) begin
      line_fill = 0;
      ph = PH_LINE_START;
    end else begin
      ph = PH_TAG;
    end
  endfunction

  function automatic void take_pat_byte(input logic [7:0] b);
    int p, idx;
    p   = pat_len_eff();
    idx = pat_pos & 7;
    pat_word[8*idx +: 8] = b;
    if (idx + 1 >= p) begin
      pat_pos = 0;
      for (int i = 0; i < int'(cnt) && line_fill < line_len_eff(); i++)
        for (int j = 0; j < p; j++) put_byte(pat_word[8*j +: 8]);
      close_cmd();
    end else begin
      pat_pos = idx + 1;
      ph = PH_PAT_DATA;
    end
  endfunction

  function automatic void take_tag(input logic [7:0] b);
    if (b == BytePatRun) begin
      ph = PH_PAT_COUNT;
    end else if (b == ByteLiteral) begin
      ph = PH_LIT_COUNT;
    end else begin
      for (int i = 0; i < int'(b & {1'b0, RunLenMask}); i++)
        put_byte(b[7] ? ByteSolidHi : ByteSolidLo);
      close_cmd();
    end
  endfunction

  // expected beats for one accepted compressed byte
  function automatic void decode_byte(input logic [7:0] b);
    acc    = '0;
    acc_n  = 0;
    n_step = 0;
    if (rows_seen >= cfg_rows) return;   // image complete: ignored
    case (ph)
      PH_LINE_START: begin
        if (b == BytePatRun) ph = PH_HDR0;
        else take_tag(b);
      end
      PH_HDR0: begin
        if (b == BytePatRun) begin
          ph = PH_HDR00;
        end else begin
          cnt = b;
          pat_pos = 0;
          ph = PH_PAT_DATA;
        end
      end
      PH_HDR00: begin
        if (b == ByteRptMark) begin
          ph = PH_HDR_N;
        end else begin
          // 00 00 x: zero-count pattern run, x is its first pattern byte
          cnt = '0;
          pat_pos = 0;
          take_pat_byte(b);
        end
      end
      PH_HDR_N: begin
        vrep = (b == 8'd0) ? 8'd1 : b;
        ph = PH_TAG;
      end
      PH_PAT_COUNT: begin
        cnt = b;
        pat_pos = 0;
        ph = PH_PAT_DATA;
      end
      PH_PAT_DATA: take_pat_byte(b);
      PH_LIT_COUNT: begin
        cnt = b;
        if (b == 8'd0) close_cmd();
        else ph = PH_LIT_DATA;
      end
      PH_LIT_DATA: begin
        put_byte(b);
        cnt = cnt - 8'd1;
        if (cnt == 8'd0) close_cmd();
      end
      default: take_tag(b);
    endcase
    pack_out(1'b0, 8'd1);
    if (n_step > 0) decoded_q[decoded_q.size()-1].fin = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Slave-side driver: offers queued bytes, idles at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (stream_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stream_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Master-side receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_ack      <= 0;
    end else if (hold_ack != hold_ask) begin
      hold_ack      <= hold_ask;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic void cmp_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Monitor: input beats feed the shadow decoder, output beats are checked
  // against the oldest expectation. Both in one process so order is fixed.
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata);
        n_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output beat: %0h last %0b", m_axis_tdata, m_axis_tlast);
          n_errors++;
        end else begin
          want = decoded_q.pop_front();
          cmp_field("decoded_bytes", want.data, m_axis_tdata[63:0]);
          cmp_field("byte_count", 64'(want.nbytes), 64'(m_axis_tdata[67:64]));
          cmp_field("line_end", 64'(want.eol), 64'(m_axis_tdata[68]));
          cmp_field("line_repeat", 64'(want.reps), 64'(m_axis_tdata[76:69]));
          cmp_field("last", 64'(want.fin), 64'(m_axis_tlast));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    stream_q.push_back(b);
    n_queued++;
  endtask

  task automatic queue_bytes(input logic [7:0] seq[]);
    foreach (seq[i]) queue_byte(seq[i]);
  endtask

  // wait until every byte is taken and every beat has come out, then let
  // the last non-emitting byte retire
  task automatic drain();
    do @(posedge clk_i); while (n_taken != n_queued || decoded_q.size() != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_LINE_BYTES:    cfg_line = val[LineW-1:0];
      CFG_PATTERN_BYTES: cfg_pat  = val[PatW-1:0];
      CFG_IMAGE_ROWS:    cfg_rows = val[RowW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input int unsigned line, input int unsigned pat,
                         input int unsigned rows);
    set_reg(CFG_LINE_BYTES, line);
    set_reg(CFG_PATTERN_BYTES, pat);
    set_reg(CFG_IMAGE_ROWS, rows);
  endtask

  // One mostly well-formed line: optional repeat header, then random solid,
  // literal and pattern commands until the line should be full. Sometimes a
  // command overruns the line on purpose.
  task automatic queue_line();
    int len, p, fill, rem, n, k;
    len  = line_len_eff();
    p    = pat_len_eff();
    fill = 0;
    if ($urandom_range(3) == 0) begin
      queue_byte(BytePatRun);
      queue_byte(BytePatRun);
      queue_byte(ByteRptMark);
      queue_byte(8'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(1, 4)));
    end
    while (fill < len) begin
      rem = len - fill;
      if ($urandom_range(9) == 0) rem += $urandom_range(1, 16);
      case ($urandom_range(3))
        0: begin    // white
          n = $urandom_range(1, (rem > 127) ? 127 : rem);
          queue_byte(n[7:0]);
        end
        1: begin    // black
          n = $urandom_range(1, (rem > 127) ? 127 : rem);
          queue_byte(ByteLiteral | n[7:0]);
        end
        2: begin    // literal
          n = $urandom_range(1, (rem > 12) ? 12 : rem);
          queue_byte(ByteLiteral);
          queue_byte(n[7:0]);
          repeat (n) queue_byte(8'($urandom_range(255)));
        end
        default: begin    // pattern run
          k = rem / p + 1;
          if (k > 255) k = 255;
          n = $urandom_range(1, k);
          queue_byte(BytePatRun);
          queue_byte(n[7:0]);
          repeat (p) queue_byte(8'($urandom_range(255)));
          n = n * p;
        end
      endcase
      fill += n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned line_tab[8];
    int unsigned pat_tab[8];
    int base;
    line_tab = '{0, 1, 512, 1023, 24, 40, 7, 80};
    pat_tab  = '{0, 8, 15, 3, 8, 5, 1, 4};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // image_rows is 0 out of reset: everything is ignored
    queue_bytes('{8'h05, 8'h85, 8'h00});
    drain();

    set_cfg(16, 2, 40);
    // repeat 0 header, zero literal, short literal, pattern, black run
    // overrunning the line
    queue_bytes('{8'h00, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h80, 8'h02, 8'h00,
                  8'hFF, 8'h00, 8'h02, 8'hAA, 8'h55, 8'hFF});
    // 00 00 x with x not FF: zero-count pattern run, then part of a line
    queue_bytes('{8'h00, 8'h00, 8'h37, 8'h21, 8'h0A});
    drain();
    // shorten the line below its fill: next command closes it silently
    set_reg(CFG_LINE_BYTES, 8);
    queue_byte(8'h83);
    drain();

    // repeat count larger than the rows left, then the image is complete
    set_reg(CFG_LINE_BYTES, 16);
    set_reg(CFG_IMAGE_ROWS, rows_seen + 2);
    queue_bytes('{8'h00, 8'h00, 8'hFF, 8'hFA, 8'h7F});
    drain();
    stream_q.push_back(8'h03);    // ignored by the decoder, still counted in n_queued
    n_queued++;
    drain();

    // random phases across register corners and handshake modes
    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      set_cfg(line_tab[ph_i], pat_tab[ph_i], 16'hFFFF);
      case (ph_i % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 65; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 65; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      base = n_queued;
      while (n_queued - base < PhaseItems) begin
        // occasional junk that breaks the command framing
        if ($urandom_range(7) == 0)
          repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
        queue_line();
      end
      // long output hold-off with the sender running flat out
      if (ph_i == 4) hold_ask = hold_ask + 1;
      drain();
    end

    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
